// File: src/etd_pkg.sv
// shared types and constants for the esc telemetry frame decoder
// no dependencies; used by etd_window, etd_crc8 and the top level
package etd_pkg;

    localparam int FRAME_LEN   = 10;
    localparam int COUNT_W     = 7;
    localparam int COUNT_LIMIT = 128;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // status codes on the result channel
    localparam logic [1:0] STATUS_NOT_READY = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
    localparam logic [1:0] STATUS_DECODED   = 2'd2;

    // ten most recent bytes, index 0 is the oldest
    typedef logic [FRAME_LEN-1:0][7:0] frame_bytes_t;

    // front stage to result stage
    typedef struct packed {
        logic         valid;
        logic         full;
        frame_bytes_t bytes;
    } front_t;

endpackage

// File: src/etd_crc8.sv
// crc-8 check of one ten-byte frame window
// depends on etd_pkg
module etd_crc8 (
    input  etd_pkg::frame_bytes_t frame_bytes,
    output logic                  crc_match
);

    // one byte through crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ etd_pkg::CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [7:0] crc_acc;

    // run over the first nine bytes and compare with the check byte
    always_comb begin
        crc_acc = 8'h00;
        for (int i = 0; i < etd_pkg::FRAME_LEN - 1; i++) begin
            crc_acc = crc8_byte(crc_acc, frame_bytes[i]);
        end
        crc_match = (crc_acc == frame_bytes[etd_pkg::FRAME_LEN-1]);
    end

endmodule

// File: src/etd_window.sv
// input stage: byte window shift line, wrapping fill count, stage valid
// depends on etd_pkg
module etd_window #(
    parameter int RING_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_func,
    input  logic [7:0]      s_rx_byte,
    input  logic            advance,
    output etd_pkg::front_t front
);

    localparam logic [etd_pkg::COUNT_W-1:0] COUNT_WRAP =
        etd_pkg::COUNT_W'(RING_DEPTH + (etd_pkg::COUNT_LIMIT % RING_DEPTH));

    logic                          valid_reg;
    logic [etd_pkg::COUNT_W-1:0]   count_reg;
    logic [etd_pkg::COUNT_W-1:0]   count_next;
    logic [etd_pkg::COUNT_W:0]     count_inc;
    etd_pkg::frame_bytes_t         window_reg;
    logic                          accept;

    assign s_ready = !valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // fill count: clear, or count up and fold back past the limit
    always_comb begin
        count_inc = {1'b0, count_reg} + 1'b1;
        if (s_func) begin
            count_next = '0;
        end else if (count_inc[etd_pkg::COUNT_W]) begin
            count_next = COUNT_WRAP;
        end else begin
            count_next = count_inc[etd_pkg::COUNT_W-1:0];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                valid_reg <= 1'b1;
            end else if (advance) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // shift line of the most recent bytes
    always_ff @(posedge aclk) begin
        if (accept && !s_func) begin
            for (int i = 0; i < etd_pkg::FRAME_LEN - 1; i++) begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[etd_pkg::FRAME_LEN-1] <= s_rx_byte;
        end
    end

    assign front.valid = valid_reg;
    assign front.full  = (count_reg >= etd_pkg::COUNT_W'(etd_pkg::FRAME_LEN));
    assign front.bytes = window_reg;

endmodule

// File: src/esc_telemetry_frame_decoder.sv
// top level of the esc telemetry frame decoder: result stage and held values
// depends on etd_pkg, etd_window and etd_crc8
// an accepted input word is registered in the byte window stage, then in the result register
// throughput: one word per cycle while m_ready does not stall the result stage; the crc over nine bytes is one
// combinational pass between the byte window register and the result register
// reset: synchronous active-low aresetn clears fill count, valids and held values
module esc_telemetry_frame_decoder #(
    parameter int RING_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_temperature_c,
    output logic [15:0] m_voltage_centivolts,
    output logic [15:0] m_current_centiamps,
    output logic [15:0] m_consumption_mah,
    output logic [15:0] m_erpm_hundreds,
    output logic [7:0]  m_frame_check
);

    etd_pkg::front_t front;
    logic            advance;
    logic            crc_match;

    logic            m_valid_reg;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    logic [7:0]      temp_reg;
    logic [15:0]     volt_reg;
    logic [15:0]     curr_reg;
    logic [15:0]     cons_reg;
    logic [15:0]     erpm_reg;
    logic [7:0]      check_reg;
    logic            load_held;

    assign advance = !m_valid_reg || m_ready;

    etd_window #(
        .RING_DEPTH(RING_DEPTH)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .front     (front)
    );

    etd_crc8 u_crc8 (
        .frame_bytes (front.bytes),
        .crc_match   (crc_match)
    );

    // frame verdict
    always_comb begin
        if (!front.full) begin
            status_next = etd_pkg::STATUS_NOT_READY;
        end else if (!crc_match) begin
            status_next = etd_pkg::STATUS_MISMATCH;
        end else begin
            status_next = etd_pkg::STATUS_DECODED;
        end
    end

    assign load_held = advance && front.valid && front.full && crc_match;

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= front.valid;
        end
    end

    // status word
    always_ff @(posedge aclk) begin
        if (advance && front.valid) begin
            status_reg <= status_next;
        end
    end

    // held telemetry, replaced by each good frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg  <= '0;
            volt_reg  <= '0;
            curr_reg  <= '0;
            cons_reg  <= '0;
            erpm_reg  <= '0;
            check_reg <= '0;
        end else if (load_held) begin
            temp_reg  <= front.bytes[0];
            volt_reg  <= {front.bytes[1], front.bytes[2]};
            curr_reg  <= {front.bytes[3], front.bytes[4]};
            cons_reg  <= {front.bytes[5], front.bytes[6]};
            erpm_reg  <= {front.bytes[7], front.bytes[8]};
            check_reg <= front.bytes[9];
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = status_reg;
    assign m_temperature_c      = temp_reg;
    assign m_voltage_centivolts = volt_reg;
    assign m_current_centiamps  = curr_reg;
    assign m_consumption_mah    = cons_reg;
    assign m_erpm_hundreds      = erpm_reg;
    assign m_frame_check        = check_reg;

    // a clear word leaves the window not full
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func |=> front.valid && !front.full)
        else $error("clear word did not empty the fill count");

    // held values only move together with a decoded result
    a_held_on_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(check_reg) || !$stable(volt_reg) |->
            m_valid_reg && status_reg == etd_pkg::STATUS_DECODED)
        else $error("held telemetry changed without a decoded frame");

    // a word leaving the front stage always lands in the result register
    a_front_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        front.valid && advance |=> m_valid_reg)
        else $error("word lost between front and result stage");

endmodule

// File: tb/esc_telemetry_frame_decoder_tb.sv
// self-checking testbench for esc_telemetry_frame_decoder: clocked driver, monitor, predictor
// depends on etd_pkg and the esc_telemetry_frame_decoder rtl
module esc_telemetry_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 16;
    localparam int TAIL_WORDS  = 150;
    localparam int TOTAL_WORDS = 1124;

    typedef struct {
        logic       func;
        logic [7:0] rx_byte;
        bit         drain;
    } tlm_word_t;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  temperature;
        logic [15:0] voltage;
        logic [15:0] current;
        logic [15:0] consumption;
        logic [15:0] erpm;
        logic [7:0]  check;
    } telem_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_func    = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_ready   = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [1:0]  m_status;
    logic [7:0]  m_temperature_c;
    logic [15:0] m_voltage_centivolts;
    logic [15:0] m_current_centiamps;
    logic [15:0] m_consumption_mah;
    logic [15:0] m_erpm_hundreds;
    logic [7:0]  m_frame_check;

    esc_telemetry_frame_decoder #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_func               (s_func),
        .s_rx_byte            (s_rx_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_temperature_c      (m_temperature_c),
        .m_voltage_centivolts (m_voltage_centivolts),
        .m_current_centiamps  (m_current_centiamps),
        .m_consumption_mah    (m_consumption_mah),
        .m_erpm_hundreds      (m_erpm_hundreds),
        .m_frame_check        (m_frame_check)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // pending words and decoded results still owed by the block
    tlm_word_t word_q[$];
    telem_t    decoded_q[$];
    int        err_count = 0;

    // shadow of the byte ring, fill count and held frame
    logic [7:0] rx_ring [RING_DEPTH];
    logic [6:0] rx_fill = '0;
    telem_t     held_frame = '{default: '0};

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = (c << 1) ^ etd_pkg::CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] crc8_frame(input logic [7:0] data [9]);
        logic [7:0] crc;
        crc = 8'h00;
        for (int k = 0; k < 9; k++) begin
            crc = crc8_next(crc, data[k]);
        end
        return crc;
    endfunction

    // apply one accepted word to the shadow state, queue the result it causes
    task automatic decode_word(input logic func, input logic [7:0] rx);
        int         n;
        int         start;
        logic [7:0] win [etd_pkg::FRAME_LEN];
        logic [7:0] body [9];
        telem_t     res;
        if (func) begin
            rx_fill = '0;
        end else begin
            rx_ring[rx_fill % RING_DEPTH] = rx;
            n = int'(rx_fill) + 1;
            // count wrap keeps the write position and stays above a frame
            if (n >= etd_pkg::COUNT_LIMIT) begin
                n = RING_DEPTH + (etd_pkg::COUNT_LIMIT % RING_DEPTH);
            end
            rx_fill = n[6:0];
        end
        res = held_frame;
        if (int'(rx_fill) < etd_pkg::FRAME_LEN) begin
            res.status = etd_pkg::STATUS_NOT_READY;
        end else begin
            start = (int'(rx_fill) - etd_pkg::FRAME_LEN) % RING_DEPTH;
            for (int k = 0; k < etd_pkg::FRAME_LEN; k++) begin
                win[k] = rx_ring[(start + k) % RING_DEPTH];
            end
            for (int k = 0; k < 9; k++) begin
                body[k] = win[k];
            end
            if (crc8_frame(body) != win[9]) begin
                res.status = etd_pkg::STATUS_MISMATCH;
            end else begin
                held_frame.temperature = win[0];
                held_frame.voltage     = {win[1], win[2]};
                held_frame.current     = {win[3], win[4]};
                held_frame.consumption = {win[5], win[6]};
                held_frame.erpm        = {win[7], win[8]};
                held_frame.check       = win[9];
                res = held_frame;
                res.status = etd_pkg::STATUS_DECODED;
            end
        end
        decoded_q.push_back(res);
    endtask

    task automatic push_word(input logic func, input logic [7:0] rx, input bit drain);
        tlm_word_t w;
        w.func    = func;
        w.rx_byte = rx;
        w.drain   = drain;
        word_q.push_back(w);
    endtask

    // nine payload bytes plus check byte; extremes mix in all-zero and all-one bytes
    task automatic push_frame(input bit corrupt, input bit extreme);
        logic [7:0] body [9];
        logic [7:0] crc;
        for (int k = 0; k < 9; k++) begin
            if (extreme && $urandom_range(0, 1)) begin
                body[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else begin
                body[k] = 8'($urandom_range(0, 255));
            end
            push_word(1'b0, body[k], 1'b0);
        end
        crc = crc8_frame(body);
        if (corrupt) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        push_word(1'b0, crc, 1'b0);
    endtask

    task automatic push_const_frame(input logic [7:0] b);
        logic [7:0] body [9];
        for (int k = 0; k < 9; k++) begin
            body[k] = b;
            push_word(1'b0, b, 1'b0);
        end
        push_word(1'b0, crc8_frame(body), 1'b0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    // driver: one word per handshake, random idle bursts, optional drain before a word
    int        drv_gap   = 0;
    int        words_sent = 0;
    bit        drv_busy;
    bit        drv_quiet;
    tlm_word_t drv_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            drv_busy = s_valid;
            if (s_valid && s_ready) begin
                decode_word(s_func, s_rx_byte);
                words_sent++;
                drv_busy = 1'b0;
            end
            drv_quiet = (word_q.size() < TAIL_WORDS) || ((words_sent / 48) % 4 == 3);
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (word_q.size() > 0 &&
                             !(word_q[0].drain && decoded_q.size() > 0)) begin
                    drv_word = word_q.pop_front();
                    s_valid   <= 1'b1;
                    s_func    <= drv_word.func;
                    s_rx_byte <= drv_word.rx_byte;
                    if (!drv_quiet && $urandom_range(0, 7) == 0) begin
                        drv_gap = $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest prediction, random stalls
    int     mon_stall  = 0;
    int     words_seen = 0;
    telem_t mon_want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                if (decoded_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual status %h",
                             $time, m_status);
                    err_count++;
                end else begin
                    mon_want = decoded_q.pop_front();
                    check_field("status", 16'(mon_want.status), 16'(m_status));
                    check_field("temperature_c", 16'(mon_want.temperature),
                                16'(m_temperature_c));
                    check_field("voltage_centivolts", mon_want.voltage, m_voltage_centivolts);
                    check_field("current_centiamps", mon_want.current, m_current_centiamps);
                    check_field("consumption_mah", mon_want.consumption, m_consumption_mah);
                    check_field("erpm_hundreds", mon_want.erpm, m_erpm_hundreds);
                    check_field("frame_check", 16'(mon_want.check), 16'(m_frame_check));
                end
            end
            if (mon_stall > 0) begin
                mon_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (word_q.size() >= TAIL_WORDS && (words_seen / 40) % 4 != 1 &&
                    $urandom_range(0, 7) == 0) begin
                    mon_stall = $urandom_range(1, 8);
                end
            end
        end
    end

    // stimulus, reset and end of run
    int  pick;
    int  burst;
    bit  drain_done = 1'b0;

    initial begin
        // directed: clear with ignored byte, all-ones frame, a shifted window,
        // clear, all-zero frame, clear
        push_word(1'b1, 8'hA5, 1'b0);
        push_const_frame(8'hFF);
        push_word(1'b0, 8'h5A, 1'b0);
        push_word(1'b1, 8'hFF, 1'b0);
        push_const_frame(8'h00);
        push_word(1'b1, 8'h00, 1'b0);

        // long run of frames without clear carries the fill count through its wrap
        push_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        for (int k = 0; k < 16; k++) begin
            push_frame(k % 5 == 4, k % 4 == 0);
        end

        // mostly well-formed frames, the rest corrupt frames, noise and clears
        while (word_q.size() < TOTAL_WORDS) begin
            if (!drain_done && word_q.size() >= 560) begin
                drain_done = 1'b1;
                push_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                push_frame(1'b0, $urandom_range(0, 5) == 0);
            end else if (pick < 67) begin
                push_frame(1'b1, $urandom_range(0, 5) == 0);
            end else if (pick < 82) begin
                burst = $urandom_range(1, 5);
                repeat (burst) push_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 90) begin
                push_word(1'b1, 8'($urandom_range(0, 255)), 1'b0);
            end else begin
                burst = $urandom_range(1, 9);
                repeat (burst) push_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                push_word(1'b1, 8'($urandom_range(0, 255)), 1'b0);
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (word_q.size() != 0 || s_valid) @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
